### rtl/smap_pkg.sv
`default_nettype none

package smap_pkg;

   localparam int POS_W      = 11;
   localparam int COUNT_W    = 11;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Result queue: an item yields at most two results.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int MAX_PUSH   = 2;

   typedef enum logic [1:0] {
      ACT_START    = 2'd0,
      ACT_PATTERN  = 2'd1,
      ACT_SENTENCE = 2'd2,
      ACT_END      = 2'd3
   } action_type;

   typedef struct packed {
      logic               is_match;
      logic [POS_W-1:0]   match_position;
      logic               is_done;
      logic [COUNT_W-1:0] match_count;
      logic               truncated;
      logic               last_in_run;
   } result_type;

endpackage

`default_nettype wire

### rtl/substring_match_all_positions.sv
// Overlapping substring search over a byte stream.
// Request channel (req_valid / req_stall): one item per accepted cycle with
// req_action and req_byte_value. A start item clears the run, pattern items
// load the pattern, sentence items stream text and an end item asks for the
// match count. Response channel (rsp_valid / rsp_stall): one result per
// handshake; a sentence item gives at most one match result, an end item gives
// the summary, preceded by a match at the sentence length when the pattern is
// empty. last_in_run marks the final result of an item.
// Throughput is one item per cycle while req_stall is low. Each result is
// registered into a four-entry queue when its item is accepted and waits there;
// req_stall rises while more than two results wait, so an end item always finds
// room for both of its results. The pattern is compared against a window of the
// newest sentence bytes in parallel, one byte comparator per pattern position.
// Reset clears the run state and empties the result queue. A stalled receiver
// only fills the queue; no result is lost, and input is held off before it overflows.
`default_nettype none

module substring_match_all_positions #(
   parameter int PATTERN_MAX  = 64,
   parameter int SENTENCE_MAX = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_action,
   input  wire logic [7:0]                  req_byte_value,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_is_match,
   output logic [smap_pkg::POS_W-1:0]       rsp_match_position,
   output logic                             rsp_is_done,
   output logic [smap_pkg::COUNT_W-1:0]     rsp_match_count,
   output logic                             rsp_truncated,
   output logic                             rsp_last_in_run
);
   import smap_pkg::*;

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int IDX_W = $clog2(SENTENCE_MAX + 1);
   localparam int CMP_W = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;

   // Pattern and window are both right aligned: entry PATTERN_MAX-1 is newest.
   logic [7:0]         pattern_ff [PATTERN_MAX];
   logic [7:0]         pattern_in [PATTERN_MAX];
   logic [7:0]         window_ff  [PATTERN_MAX];
   logic [7:0]         window_in  [PATTERN_MAX];
   logic [LEN_W-1:0]   length_ff, length_in;
   logic [IDX_W-1:0]   index_ff, index_in;
   logic [COUNT_W-1:0] found_ff, found_in;
   logic               overflow_ff, overflow_in;
   logic               started_ff, started_in;

   result_type         fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;

   logic               accept, pop;
   logic [1:0]         push_n;
   result_type         res0, res1;
   logic               window_hit;
   logic [CMP_W-1:0]   index_next_w, length_w, pos_w;
   action_type         action;

   assign action    = action_type'(req_action);
   assign req_stall = count_ff > FIFO_CNT_W'(FIFO_DEPTH - MAX_PUSH);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;

   assign index_next_w = CMP_W'(index_ff) + CMP_W'(1);
   assign length_w     = CMP_W'(length_ff);
   assign pos_w        = index_next_w - length_w;

   // Window and pattern after the item's byte is shifted in.
   always_comb begin
      for (int k = 0; k < PATTERN_MAX - 1; k++) begin
         window_in[k]  = window_ff[k + 1];
         pattern_in[k] = pattern_ff[k + 1];
      end
      window_in[PATTERN_MAX - 1]  = req_byte_value;
      pattern_in[PATTERN_MAX - 1] = req_byte_value;
   end

   // Only the newest length_ff entries take part in the compare.
   always_comb begin
      window_hit = 1'b1;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         if ((PATTERN_MAX - k) <= int'(length_ff) && window_in[k] != pattern_ff[k]) begin
            window_hit = 1'b0;
         end
      end
   end

   always_comb begin
      length_in   = length_ff;
      index_in    = index_ff;
      found_in    = found_ff;
      overflow_in = overflow_ff;
      started_in  = started_ff;
      push_n      = 2'd0;
      res0        = '0;
      res1        = '0;
      unique case (action)
         ACT_START: begin
            length_in   = '0;
            index_in    = '0;
            found_in    = '0;
            overflow_in = 1'b0;
            started_in  = 1'b0;
         end
         ACT_PATTERN: begin
            if (!started_ff) begin
               if (int'(length_ff) < PATTERN_MAX) begin
                  length_in = length_ff + LEN_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
            end
         end
         ACT_SENTENCE: begin
            started_in = 1'b1;
            if (int'(index_ff) >= SENTENCE_MAX) begin
               overflow_in = 1'b1;
            end else begin
               index_in = index_ff + IDX_W'(1);
               if (length_ff == '0) begin
                  push_n              = 2'd1;
                  res0.is_match       = 1'b1;
                  res0.match_position = POS_W'(index_ff);
               end else if (index_next_w >= length_w && window_hit) begin
                  push_n              = 2'd1;
                  res0.is_match       = 1'b1;
                  res0.match_position = POS_W'(pos_w);
               end
               if (push_n != 2'd0 && found_ff != COUNT_MAX) begin
                  found_in = found_ff + COUNT_W'(1);
               end
            end
         end
         ACT_END: begin
            if (length_ff == '0) begin
               if (found_ff != COUNT_MAX) begin
                  found_in = found_ff + COUNT_W'(1);
               end
               push_n              = 2'd2;
               res0.is_match       = 1'b1;
               res0.match_position = POS_W'(index_ff);
               res1.is_done        = 1'b1;
               res1.match_count    = found_in;
               res1.last_in_run    = 1'b1;
            end else begin
               push_n           = 2'd1;
               res0.is_done     = 1'b1;
               res0.match_count = found_ff;
            end
         end
         default: begin
         end
      endcase
      res0.truncated = overflow_in;
      res1.truncated = overflow_in;
      if (push_n == 2'd1) begin
         res0.last_in_run = 1'b1;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_n);
         count_in  = count_in + FIFO_CNT_W'(push_n);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(1);
         count_in  = count_in - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= '0;
         index_ff    <= '0;
         found_ff    <= '0;
         overflow_ff <= 1'b0;
         started_ff  <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         if (accept) begin
            length_ff   <= length_in;
            index_ff    <= index_in;
            found_ff    <= found_in;
            overflow_ff <= overflow_in;
            started_ff  <= started_in;
         end
      end
   end

   // Pattern and window bytes are only read once written since the last start.
   always_ff @(posedge clock) begin
      if (accept && action == ACT_PATTERN && !started_ff
          && int'(length_ff) < PATTERN_MAX) begin
         pattern_ff <= pattern_in;
      end
      if (accept && action == ACT_SENTENCE && int'(index_ff) < SENTENCE_MAX) begin
         window_ff <= window_in;
      end
      for (int e = 0; e < FIFO_DEPTH; e++) begin
         if (accept && push_n != 2'd0 && FIFO_PTR_W'(e) == wr_ptr_ff) begin
            fifo_ff[e] <= res0;
         end
         if (accept && push_n == 2'd2 && FIFO_PTR_W'(e) == wr_ptr_ff + FIFO_PTR_W'(1)) begin
            fifo_ff[e] <= res1;
         end
      end
   end

   assign rsp_is_match       = fifo_ff[rd_ptr_ff].is_match;
   assign rsp_match_position = fifo_ff[rd_ptr_ff].match_position;
   assign rsp_is_done        = fifo_ff[rd_ptr_ff].is_done;
   assign rsp_match_count    = fifo_ff[rd_ptr_ff].match_count;
   assign rsp_truncated      = fifo_ff[rd_ptr_ff].truncated;
   assign rsp_last_in_run    = fifo_ff[rd_ptr_ff].last_in_run;

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue holds more items than its depth");

   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (accept && action == ACT_END) |=> rsp_valid)
      else $error("end item produced no summary result");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      int'(length_ff) <= PATTERN_MAX)
      else $error("pattern length beyond capacity");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && action == ACT_START) |=> (found_ff == '0 && index_ff == '0
                                           && !started_ff && !overflow_ff))
      else $error("start item did not clear the run state");

endmodule

`default_nettype wire

### test/substring_match_checker.sv
`timescale 1ns / 100ps

module substring_match_checker #(
   parameter int PATTERN_MAX  = 64,
   parameter int SENTENCE_MAX = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [1:0]                   req_action,
   input  logic [7:0]                   req_byte_value,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic                         rsp_is_match,
   input  logic [smap_pkg::POS_W-1:0]   rsp_match_position,
   input  logic                         rsp_is_done,
   input  logic [smap_pkg::COUNT_W-1:0] rsp_match_count,
   input  logic                         rsp_truncated,
   input  logic                         rsp_last_in_run,
   output int                           mismatch_count,
   output int                           pending_results
);
   import smap_pkg::*;

   logic [7:0]         pattern_bytes [PATTERN_MAX];
   int                 pattern_len;
   logic [7:0]         window [PATTERN_MAX];
   int                 sentence_len;
   logic [COUNT_W-1:0] found;
   logic               overflowed;
   logic               sentence_begun;
   result_type         awaited_results [$];

   function automatic result_type make_result(input logic hit, input int pos,
                                              input logic done,
                                              input logic [COUNT_W-1:0] cnt);
      result_type r;
      r.is_match       = hit;
      r.match_position = pos[POS_W-1:0];
      r.is_done        = done;
      r.match_count    = cnt;
      r.truncated      = overflowed;
      r.last_in_run    = 1'b0;
      return r;
   endfunction

   task automatic clear_search();
      int j;
      pattern_len = 0;
      for (j = 0; j < PATTERN_MAX; j++) begin
         window[j] = 8'h00;
      end
      sentence_len   = 0;
      found          = '0;
      overflowed     = 1'b0;
      sentence_begun = 1'b0;
   endtask

   task automatic count_hit();
      if (found != COUNT_MAX) begin
         found = found + 1'b1;
      end
   endtask

   // Works out the results of one accepted item and queues them in order.
   task automatic advance_search(input action_type act, input logic [7:0] value);
      result_type outs [2];
      int         n;
      int         j;
      logic       hit;
      n = 0;
      case (act)
         ACT_START: begin
            clear_search();
         end
         ACT_PATTERN: begin
            if (!sentence_begun) begin
               if (pattern_len < PATTERN_MAX) begin
                  pattern_bytes[pattern_len] = value;
                  pattern_len++;
               end else begin
                  overflowed = 1'b1;
               end
            end
         end
         ACT_SENTENCE: begin
            sentence_begun = 1'b1;
            if (sentence_len >= SENTENCE_MAX) begin
               overflowed = 1'b1;
            end else begin
               for (j = 0; j < PATTERN_MAX - 1; j++) begin
                  window[j] = window[j+1];
               end
               window[PATTERN_MAX-1] = value;
               sentence_len++;
               if (pattern_len == 0) begin
                  count_hit();
                  outs[n] = make_result(1'b1, sentence_len - 1, 1'b0, '0);
                  n++;
               end else if (sentence_len >= pattern_len) begin
                  // The newest pattern_len bytes sit at the top of the window.
                  hit = 1'b1;
                  for (j = 0; j < pattern_len; j++) begin
                     if (window[PATTERN_MAX-pattern_len+j] != pattern_bytes[j]) begin
                        hit = 1'b0;
                     end
                  end
                  if (hit) begin
                     count_hit();
                     outs[n] = make_result(1'b1, sentence_len - pattern_len, 1'b0, '0);
                     n++;
                  end
               end
            end
         end
         default: begin
            // An empty pattern also matches just past the last byte.
            if (pattern_len == 0) begin
               count_hit();
               outs[n] = make_result(1'b1, sentence_len, 1'b0, '0);
               n++;
            end
            outs[n] = make_result(1'b0, 0, 1'b1, found);
            n++;
         end
      endcase
      if (n > 0) begin
         outs[n-1].last_in_run = 1'b1;
      end
      for (j = 0; j < n; j++) begin
         awaited_results.push_back(outs[j]);
      end
   endtask

   task automatic check_result();
      result_type got;
      result_type want;
      got.is_match       = rsp_is_match;
      got.match_position = rsp_match_position;
      got.is_done        = rsp_is_done;
      got.match_count    = rsp_match_count;
      got.truncated      = rsp_truncated;
      got.last_in_run    = rsp_last_in_run;
      if (awaited_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("%0t: unexpected result", $time);
            $display("   actual   match=%0b pos=%0d done=%0b count=%0d trunc=%0b last=%0b",
                     got.is_match, got.match_position, got.is_done,
                     got.match_count, got.truncated, got.last_in_run);
         end
      end else begin
         want = awaited_results.pop_front();
         if (got.is_match !== want.is_match || got.match_position !== want.match_position ||
             got.is_done !== want.is_done || got.match_count !== want.match_count ||
             got.truncated !== want.truncated || got.last_in_run !== want.last_in_run) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: result mismatch", $time);
               $display("   expected match=%0b pos=%0d done=%0b count=%0d trunc=%0b last=%0b",
                        want.is_match, want.match_position, want.is_done,
                        want.match_count, want.truncated, want.last_in_run);
               $display("   actual   match=%0b pos=%0d done=%0b count=%0d trunc=%0b last=%0b",
                        got.is_match, got.match_position, got.is_done,
                        got.match_count, got.truncated, got.last_in_run);
            end
         end
      end
   endtask

   // A result seen at an edge always belongs to an item accepted earlier,
   // so it is checked before the item of the same edge is predicted.
   always @(posedge clock) begin
      if (reset) begin
         clear_search();
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result();
         end
         if (req_valid && !req_stall) begin
            advance_search(action_type'(req_action), req_byte_value);
         end
      end
      pending_results = awaited_results.size();
   end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import smap_pkg::*;

   localparam int PATTERN_MAX  = 64;
   localparam int SENTENCE_MAX = 1024;
   localparam int LONG_HOLD    = 300;
   localparam int RANDOM_ITEMS = 290;
   localparam int CYCLE_LIMIT  = 400000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_action;
   logic [7:0]         req_byte_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_is_match;
   logic [POS_W-1:0]   rsp_match_position;
   logic               rsp_is_done;
   logic [COUNT_W-1:0] rsp_match_count;
   logic               rsp_truncated;
   logic               rsp_last_in_run;
   int                 mismatch_count;
   int                 pending_results;

   int   cycle_count   = 0;
   int   hold_requests = 0;
   int   random_items  = 0;
   logic sender_steady;
   logic receiver_steady;

   substring_match_all_positions #(
      .PATTERN_MAX  (PATTERN_MAX),
      .SENTENCE_MAX (SENTENCE_MAX)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_byte_value     (req_byte_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_is_match       (rsp_is_match),
      .rsp_match_position (rsp_match_position),
      .rsp_is_done        (rsp_is_done),
      .rsp_match_count    (rsp_match_count),
      .rsp_truncated      (rsp_truncated),
      .rsp_last_in_run    (rsp_last_in_run)
   );

   substring_match_checker #(
      .PATTERN_MAX  (PATTERN_MAX),
      .SENTENCE_MAX (SENTENCE_MAX)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_byte_value     (req_byte_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_is_match       (rsp_is_match),
      .rsp_match_position (rsp_match_position),
      .rsp_is_done        (rsp_is_done),
      .rsp_match_count    (rsp_match_count),
      .rsp_truncated      (rsp_truncated),
      .rsp_last_in_run    (rsp_last_in_run),
      .mismatch_count     (mismatch_count),
      .pending_results    (pending_results)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int idle_draw(input logic steady);
      return steady ? 0 : $urandom_range(0, 6);
   endfunction

   // Called and returns at a falling edge; valid stays high when the next
   // item follows without a gap.
   task automatic send_item(input action_type act, input logic [7:0] value);
      int gap;
      gap = idle_draw(sender_steady);
      repeat (gap) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_action     = act;
      req_byte_value = value;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_valid = 1'b0;
      while (pending_results != 0) begin
         @(negedge clock);
      end
   endtask

   // Mostly well-formed searches over a two-symbol alphabet so that matches
   // are frequent; now and then pure noise.
   task automatic random_sequence();
      logic [7:0] sym_a;
      logic [7:0] sym_b;
      int         plen;
      int         slen;
      int         rounds;
      int         k;
      sender_steady   = ($urandom_range(0, 3) == 0);
      receiver_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) begin
            send_item(action_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            random_items++;
         end
      end else begin
         sym_a = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 3) == 0) begin
            sym_b = 8'($urandom_range(0, 255));
         end else begin
            sym_b = sym_a ^ (8'd1 << $urandom_range(0, 7));
         end
         if ($urandom_range(0, 7) != 0) begin
            send_item(ACT_START, 8'($urandom_range(0, 255)));
            random_items++;
         end
         plen = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4);
         repeat (plen) begin
            send_item(ACT_PATTERN, $urandom_range(0, 1) ? sym_a : sym_b);
            random_items++;
         end
         rounds = ($urandom_range(0, 3) == 0) ? 2 : 1;
         repeat (rounds) begin
            slen = $urandom_range(0, 30);
            for (k = 0; k < slen; k++) begin
               // A pattern item before the first sentence byte still extends the pattern; later ones are ignored.
               if ($urandom_range(0, 19) == 0) begin
                  send_item(ACT_PATTERN, 8'($urandom_range(0, 255)));
               end
               send_item(ACT_SENTENCE, $urandom_range(0, 1) ? sym_a : sym_b);
               random_items++;
            end
            send_item(ACT_END, 8'($urandom_range(0, 255)));
            random_items++;
         end
      end
      if ($urandom_range(0, 5) == 0) begin
         wait_for_results();
      end
   endtask

   initial begin : receiver
      int wait_left;
      int hold_left;
      int holds_served;
      rsp_stall    = 1'b0;
      wait_left    = 0;
      hold_left    = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            wait_left = idle_draw(receiver_steady);
         end else if (wait_left > 0) begin
            wait_left--;
         end
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
         end else if (hold_left > 0) begin
            hold_left--;
         end
         @(negedge clock);
         rsp_stall = (wait_left > 0) || (hold_left > 0);
      end
   end

   initial begin : stimulus
      logic [7:0] long_pattern [PATTERN_MAX];
      int         k;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = ACT_START;
      req_byte_value  = 8'h00;
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty pattern straight after reset, then overlapping matches, a
      // pattern item after the sentence began, and zero as a character.
      send_item(ACT_END, 8'h00);
      send_item(ACT_START, 8'hFF);
      send_item(ACT_PATTERN, 8'h61);
      send_item(ACT_PATTERN, 8'h61);
      send_item(ACT_SENTENCE, 8'h61);
      send_item(ACT_SENTENCE, 8'h61);
      send_item(ACT_PATTERN, 8'h61);
      send_item(ACT_SENTENCE, 8'h61);
      send_item(ACT_SENTENCE, 8'h00);
      send_item(ACT_END, 8'h00);
      send_item(ACT_START, 8'h00);
      send_item(ACT_END, 8'hFF);
      send_item(ACT_SENTENCE, 8'hFF);
      send_item(ACT_SENTENCE, 8'h00);
      send_item(ACT_END, 8'h00);
      send_item(ACT_START, 8'h00);
      send_item(ACT_PATTERN, 8'h00);
      send_item(ACT_PATTERN, 8'hFF);
      send_item(ACT_SENTENCE, 8'h00);
      send_item(ACT_SENTENCE, 8'hFF);
      send_item(ACT_SENTENCE, 8'h00);
      send_item(ACT_SENTENCE, 8'hFF);
      send_item(ACT_END, 8'hFF);

      // Full-length pattern plus one byte too many, found twice in the text.
      wait_for_results();
      send_item(ACT_START, 8'h00);
      for (k = 0; k < PATTERN_MAX; k++) begin
         long_pattern[k] = $urandom_range(0, 1) ? 8'hA5 : 8'h5A;
         send_item(ACT_PATTERN, long_pattern[k]);
      end
      send_item(ACT_PATTERN, 8'h3C);
      repeat (3) send_item(ACT_SENTENCE, 8'($urandom_range(0, 255)));
      repeat (2) begin
         for (k = 0; k < PATTERN_MAX; k++) begin
            send_item(ACT_SENTENCE, long_pattern[k]);
         end
      end
      send_item(ACT_END, 8'h00);

      // The receiver holds off while every sentence byte makes a result, so
      // the result queue fills and the input stalls; then the sender pauses.
      wait_for_results();
      sender_steady = 1'b1;
      hold_requests++;
      send_item(ACT_START, 8'h00);
      repeat (40) send_item(ACT_SENTENCE, 8'($urandom_range(0, 255)));
      send_item(ACT_END, 8'h00);
      wait_for_results();

      while (random_items < RANDOM_ITEMS) begin
         random_sequence();
      end

      wait_for_results();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
